@@ design/brf_pkg.sv @@
// Shared constants and request codes for the byte ring FIFO with peek.
`default_nettype none

package brf_pkg;

   localparam int SIZE_W  = 9;
   localparam int BYTE_W  = 8;
   localparam int LEN_W   = 7;
   localparam int COUNT_W = 8;

   localparam int SIZE_MIN = 2;
   localparam int SIZE_MAX = (1 << SIZE_W) - 1;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

   localparam logic [1:0] REQ_PUT   = 2'd0;
   localparam logic [1:0] REQ_GET   = 2'd1;
   localparam logic [1:0] REQ_PEEK  = 2'd2;
   localparam logic [1:0] REQ_CLEAR = 2'd3;

endpackage

`default_nettype wire

@@ design/byte_ring_fifo_with_peek_top.sv @@
// Top level of the byte ring FIFO with put, get, peek and clear requests.
//
//  Channel   Direction  Handshake             Contents
//  req_      in         req_valid/req_stall   req_type, req_write_byte, req_read_length
//  rsp_      out        rsp_valid/rsp_stall   byte, flags, used count, free space, empty
//  csr_      in         csr_wr_en             size_in_use (9 bits), clears both pointers and the count
//
// Put, clear and empty get or peek requests each give one response; puts stream at one per cycle while
// the response is not stalled. A get or peek of n bytes reads the byte store through its single read
// port, one byte per cycle, and the next request is taken after its last byte reaches the response.
// Reset is synchronous, clears the pointers and the count and sets the size register to 256.
// A stalled response holds the run; the store read is held until the byte can be passed on.
`default_nettype none

module byte_ring_fifo_with_peek_top
   import brf_pkg::*;
#(
   parameter int STORE_DEPTH = 256,
   parameter int MAX_RUN     = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_type,
   input  wire logic [BYTE_W-1:0]  req_write_byte,
   input  wire logic [LEN_W-1:0]   req_read_length,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic      [BYTE_W-1:0]  rsp_read_byte,
   output logic                    rsp_byte_valid,
   output logic                    rsp_put_accepted,
   output logic                    rsp_last_of_run,
   output logic      [COUNT_W-1:0] rsp_used_count,
   output logic      [COUNT_W-1:0] rsp_free_space,
   output logic                    rsp_is_empty,
   input  wire logic               csr_wr_en,
   input  wire logic [SIZE_W-1:0]  csr_wr_data
);

   localparam int EFF_DEPTH = (STORE_DEPTH < SIZE_MAX) ? STORE_DEPTH : SIZE_MAX;
   localparam int PW        = $clog2(EFF_DEPTH);
   localparam int SW        = $clog2(EFF_DEPTH + 1);
   localparam int RW        = $clog2(MAX_RUN + 1);
   localparam int XW        = 12;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic              state_ff, state_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [PW-1:0]     wp_ff, wp_in;
   logic [PW-1:0]     rp_ff, rp_in;
   logic [PW-1:0]     run_ptr_ff, run_ptr_in;
   logic [SW-1:0]     used_ff, used_in;
   logic [RW-1:0]     remain_ff, remain_in;
   logic              consume_ff, consume_in;
   logic              pend_ff, pend_in;
   logic              pend_last_ff, pend_last_in;
   logic [SW-1:0]     pend_used_ff, pend_used_in;
   logic              out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic              out_bvalid_ff, out_bvalid_in;
   logic              out_acc_ff, out_acc_in;
   logic              out_last_ff, out_last_in;
   logic [SW-1:0]     out_used_ff, out_used_in;

   logic [SW-1:0]     eff_size;
   logic [PW-1:0]     wp_next;
   logic [PW-1:0]     run_next;
   logic              req_take;
   logic              out_free;
   logic              load_pend;
   logic              issue;
   logic              room;
   logic [XW-1:0]     len_cap;
   logic [XW-1:0]     run_len;
   logic              mem_wr_en;
   logic [BYTE_W-1:0] mem_rd_data;

   function automatic logic [PW-1:0] advance(input logic [PW-1:0] p, input logic [SW-1:0] s);
      logic [SW-1:0] n;
      n = SW'(p) + SW'(1);
      if (n >= s) begin
         n = '0;
      end
      return PW'(n);
   endfunction

   always_comb begin
      if (XW'(size_ff) < XW'(SIZE_MIN)) begin
         eff_size = SW'(SIZE_MIN);
      end else if (XW'(size_ff) > XW'(EFF_DEPTH)) begin
         eff_size = SW'(EFF_DEPTH);
      end else begin
         eff_size = SW'(size_ff);
      end
   end

   assign wp_next   = advance(wp_ff, eff_size);
   assign run_next  = advance(run_ptr_ff, eff_size);
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) && !pend_ff && out_free);
   assign req_take  = req_valid && !req_stall;
   assign load_pend = pend_ff && out_free;
   assign issue     = (state_ff == ST_RUN) && (!pend_ff || load_pend);
   assign room      = XW'(used_ff) < (XW'(eff_size) - XW'(1));
   assign len_cap   = (XW'(req_read_length) > XW'(MAX_RUN)) ? XW'(MAX_RUN)
                                                            : XW'(req_read_length);
   assign run_len   = (len_cap > XW'(used_ff)) ? XW'(used_ff) : len_cap;
   assign mem_wr_en = req_take && (req_type == REQ_PUT) && room;

   always_comb begin
      state_in      = state_ff;
      size_in       = size_ff;
      wp_in         = wp_ff;
      rp_in         = rp_ff;
      run_ptr_in    = run_ptr_ff;
      used_in       = used_ff;
      remain_in     = remain_ff;
      consume_in    = consume_ff;
      pend_in       = pend_ff;
      pend_last_in  = pend_last_ff;
      pend_used_in  = pend_used_ff;
      out_valid_in  = out_valid_ff;
      out_byte_in   = out_byte_ff;
      out_bvalid_in = out_bvalid_ff;
      out_acc_in    = out_acc_ff;
      out_last_in   = out_last_ff;
      out_used_in   = out_used_ff;

      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end

      if (req_take) begin
         out_valid_in  = 1'b1;
         out_byte_in   = '0;
         out_bvalid_in = 1'b0;
         out_acc_in    = 1'b0;
         out_last_in   = 1'b1;
         out_used_in   = used_ff;
         case (req_type)
            REQ_PUT: begin
               if (room) begin
                  wp_in       = wp_next;
                  used_in     = used_ff + SW'(1);
                  out_used_in = used_ff + SW'(1);
                  out_acc_in  = 1'b1;
               end
            end
            REQ_GET, REQ_PEEK: begin
               if (run_len != '0) begin
                  out_valid_in = 1'b0;
                  state_in     = ST_RUN;
                  run_ptr_in   = rp_ff;
                  remain_in    = RW'(run_len);
                  consume_in   = (req_type == REQ_GET);
               end
            end
            REQ_CLEAR: begin
               wp_in       = '0;
               rp_in       = '0;
               used_in     = '0;
               out_used_in = '0;
            end
            default: begin
               out_used_in = used_ff;
            end
         endcase
      end else if (load_pend) begin
         out_valid_in  = 1'b1;
         out_byte_in   = mem_rd_data;
         out_bvalid_in = 1'b1;
         out_acc_in    = 1'b0;
         out_last_in   = pend_last_ff;
         out_used_in   = pend_used_ff;
         pend_in       = 1'b0;
      end

      if (issue) begin
         pend_in      = 1'b1;
         pend_last_in = (remain_ff == RW'(1));
         run_ptr_in   = run_next;
         remain_in    = remain_ff - RW'(1);
         if (consume_ff) begin
            used_in      = used_ff - SW'(1);
            pend_used_in = used_ff - SW'(1);
         end else begin
            pend_used_in = used_ff;
         end
         if (remain_ff == RW'(1)) begin
            state_in = ST_IDLE;
            if (consume_ff) begin
               rp_in = run_next;
            end
         end
      end

      if (csr_wr_en) begin
         size_in = csr_wr_data;
         wp_in   = '0;
         rp_in   = '0;
         used_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         size_ff      <= SIZE_RESET;
         wp_ff        <= '0;
         rp_ff        <= '0;
         run_ptr_ff   <= '0;
         used_ff      <= '0;
         remain_ff    <= '0;
         consume_ff   <= 1'b0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         run_ptr_ff   <= run_ptr_in;
         used_ff      <= used_in;
         remain_ff    <= remain_in;
         consume_ff   <= consume_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_last_ff  <= pend_last_in;
      pend_used_ff  <= pend_used_in;
      out_byte_ff   <= out_byte_in;
      out_bvalid_ff <= out_bvalid_in;
      out_acc_ff    <= out_acc_in;
      out_last_ff   <= out_last_in;
      out_used_ff   <= out_used_in;
   end

   brf_ram #(
      .WIDTH(BYTE_W),
      .DEPTH(EFF_DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (mem_wr_en),
      .wr_addr(wp_ff),
      .wr_data(req_write_byte),
      .rd_en  (issue),
      .rd_addr(run_ptr_ff),
      .rd_data(mem_rd_data)
   );

   assign rsp_valid        = out_valid_ff;
   assign rsp_read_byte    = out_byte_ff;
   assign rsp_byte_valid   = out_bvalid_ff;
   assign rsp_put_accepted = out_acc_ff;
   assign rsp_last_of_run  = out_last_ff;
   assign rsp_used_count   = COUNT_W'(out_used_ff);
   assign rsp_free_space   = COUNT_W'(XW'(eff_size) - XW'(1) - XW'(out_used_ff));
   assign rsp_is_empty     = (out_used_ff == '0);

endmodule

`default_nettype wire

@@ design/brf_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module brf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
